@@ design/exclusive_time_profiler_macros.svh @@
// Assertion macros shared by the profiler RTL.
`ifndef EXCLUSIVE_TIME_PROFILER_MACROS_SVH
`define EXCLUSIVE_TIME_PROFILER_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, quiet while reset is asserted.
`define ETP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define ETP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ETP_ASSERT(lbl, prop, msg)
`define ETP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/etp_pkg.sv @@
package etp_pkg;

  localparam int unsigned MAX_FUNCS   = 128;
  localparam int unsigned STACK_DEPTH = 64;

  localparam int unsigned FID_W   = 7;
  localparam int unsigned TS_W    = 31;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SPTR_W  = $clog2(STACK_DEPTH);

  localparam logic [CNT_W-1:0]   FUNC_COUNT_RST = CNT_W'(128);
  localparam logic [DEPTH_W-1:0] STACK_FULL     = DEPTH_W'(STACK_DEPTH);
  localparam logic [FID_W:0]     FUNC_LIMIT     = (FID_W + 1)'(MAX_FUNCS);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

endpackage

@@ design/etp_evt_if.sv @@
interface etp_evt_if;
  logic                      valid;
  logic                      ready;
  logic                      is_end;
  logic [etp_pkg::FID_W-1:0] func_id;
  logic [etp_pkg::TS_W-1:0]  timestamp;

  modport source (output valid, is_end, func_id, timestamp, input ready);
  modport sink   (input valid, is_end, func_id, timestamp, output ready);
endinterface

@@ design/etp_res_if.sv @@
interface etp_res_if;
  logic                      valid;
  logic                      ready;
  etp_pkg::status_e          status;
  logic                      updated;
  logic [etp_pkg::FID_W-1:0] charged_id;
  logic [etp_pkg::TOT_W-1:0] new_total;

  modport source (output valid, status, updated, charged_id, new_total, input ready);
  modport sink   (input valid, status, updated, charged_id, new_total, output ready);
endinterface

@@ design/etp_cfg_if.sv @@
interface etp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [etp_pkg::CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ design/exclusive_time_profiler.sv @@
// Exclusive time profiler: takes parsed trace events (start/end, function id,
// timestamp) on evt_i and returns exactly one result per event on res_o:
// status, whether a total changed, which function, and its new 32-bit total.
// One event is taken every cycle unless the result side stalls; each result
// passes through the second-stage register and then the output register. The
// totals memory is read in the accept cycle, and the add and write-back happen
// as the event leaves the second stage, with a one-entry bypass for back-to-back
// hits on the same function. The call stack keeps its top in a register; a pop
// refills it from the stack memory with a registered read that is picked up
// directly the next cycle. Totals start at zero after reset through per-entry
// valid flops, so no clearing pass is needed. function_count is written on cfg_i
// (always ready) and should only change while no event is in flight.
`include "exclusive_time_profiler_macros.svh"

module exclusive_time_profiler (
  input  logic      clk_i,
  input  logic      rst_ni,
  etp_evt_if.sink   evt_i,
  etp_cfg_if.sink   cfg_i,
  etp_res_if.source res_o
);

  // ---------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------
  logic [etp_pkg::CNT_W-1:0]   fc_q;        // function_count register
  logic [etp_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic [etp_pkg::TOT_W-1:0]   slice_q, slice_d;
  logic [etp_pkg::FID_W-1:0]   top_q, top_d;
  logic                        pop_last_q;  // top lives in stk_rd_q
  logic [etp_pkg::FID_W-1:0]   stk_rd_q;

  // Stack memory holds every entry below the top.
  logic [etp_pkg::FID_W-1:0]   stk_mem [etp_pkg::STACK_DEPTH];
  // Totals memory plus per-entry valid flops (unwritten entries read zero).
  logic [etp_pkg::TOT_W-1:0]   tot_mem [etp_pkg::MAX_FUNCS];
  logic [etp_pkg::MAX_FUNCS-1:0] tv_q;
  logic [etp_pkg::TOT_W-1:0]   tot_rd_q;

  // Second stage: decoded event waiting for its total update.
  logic                        s2_valid_q;
  etp_pkg::status_e            s2_status_q;
  logic                        s2_upd_q;
  logic [etp_pkg::FID_W-1:0]   s2_id_q;
  logic [etp_pkg::TOT_W-1:0]   s2_delta_q;

  // Last write to the totals memory, for the bypass.
  logic                        wb_valid_q;
  logic [etp_pkg::FID_W-1:0]   wb_id_q;
  logic [etp_pkg::TOT_W-1:0]   wb_total_q;

  // Output register.
  logic                        res_valid_q;
  etp_pkg::status_e            res_status_q;
  logic                        res_upd_q;
  logic [etp_pkg::FID_W-1:0]   res_id_q;
  logic [etp_pkg::TOT_W-1:0]   res_total_q;

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic s2_adv, accept;

  assign s2_adv      = s2_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !s2_valid_q || s2_adv;
  assign accept      = evt_i.valid && evt_i.ready;
  assign cfg_i.ready = 1'b1;

  // ---------------------------------------------------------------------
  // Event decode (accept cycle)
  // ---------------------------------------------------------------------
  logic [etp_pkg::FID_W-1:0]   top;
  logic                        in_range, is_empty, is_full;
  logic [etp_pkg::TOT_W-1:0]   ts_ext, diff;
  logic [etp_pkg::DEPTH_W-1:0] depth_m1, depth_m2;
  logic [etp_pkg::SPTR_W-1:0]  push_addr, pop_addr;
  etp_pkg::status_e            status;
  logic                        upd, do_push, do_pop;
  logic [etp_pkg::FID_W-1:0]   chg_id;
  logic [etp_pkg::TOT_W-1:0]   delta;

  assign top       = pop_last_q ? stk_rd_q : top_q;
  assign in_range  = ({1'b0, evt_i.func_id} < fc_q)
                     && ({1'b0, evt_i.func_id} < etp_pkg::FUNC_LIMIT);
  assign is_empty  = (depth_q == '0);
  assign is_full   = (depth_q >= etp_pkg::STACK_FULL);
  assign ts_ext    = {1'b0, evt_i.timestamp};
  assign diff      = ts_ext - slice_q;
  assign depth_m1  = depth_q - 1'b1;
  assign depth_m2  = depth_q - 2'd2;
  assign push_addr = depth_m1[etp_pkg::SPTR_W-1:0];
  assign pop_addr  = depth_m2[etp_pkg::SPTR_W-1:0];

  always_comb begin
    status  = etp_pkg::ST_OK;
    upd     = 1'b0;
    do_push = 1'b0;
    do_pop  = 1'b0;
    chg_id  = top;
    delta   = diff;
    slice_d = slice_q;
    depth_d = depth_q;
    if (!in_range) begin
      // Range check wins over every other case.
      status = etp_pkg::ST_RANGE;
    end else if (evt_i.is_end) begin
      if (is_empty) begin
        status = etp_pkg::ST_EMPTY;
      end else begin
        // Pop; the named function is charged, inclusive of its timestamp.
        do_pop  = 1'b1;
        upd     = 1'b1;
        chg_id  = evt_i.func_id;
        delta   = diff + 1'b1;
        slice_d = ts_ext + 1'b1;
        depth_d = depth_m1;
      end
    end else if (is_full) begin
      status = etp_pkg::ST_OVERFLOW;
    end else begin
      // Push; interrupted top (if any) is charged up to the timestamp.
      do_push = 1'b1;
      upd     = !is_empty;
      slice_d = ts_ext;
      depth_d = depth_q + 1'b1;
    end
  end

  always_comb begin
    top_d = top;
    if (accept && do_push) begin
      top_d = evt_i.func_id;
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= etp_pkg::FUNC_COUNT_RST;
      depth_q     <= '0;
      slice_q     <= '0;
      pop_last_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      tv_q        <= '0;
    end else begin
      if (cfg_i.valid) begin
        fc_q <= cfg_i.data;
      end
      if (accept) begin
        depth_q <= depth_d;
        slice_q <= slice_d;
      end
      pop_last_q <= accept && do_pop;
      if (accept) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (s2_adv && s2_upd_q) begin
        wb_valid_q       <= 1'b1;
        tv_q[s2_id_q]    <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stack memory and top register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (accept && do_push && !is_empty) begin
      stk_mem[push_addr] <= top;
    end
    if (accept && do_pop) begin
      stk_rd_q <= stk_mem[pop_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Totals read-modify-write
  // ---------------------------------------------------------------------
  logic [etp_pkg::TOT_W-1:0] base, sum;

  always_comb begin
    if (wb_valid_q && (wb_id_q == s2_id_q)) begin
      base = wb_total_q;
    end else if (tv_q[s2_id_q]) begin
      base = tot_rd_q;
    end else begin
      base = '0;
    end
  end

  assign sum = base + s2_delta_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tot_rd_q    <= tot_mem[chg_id];
      s2_status_q <= status;
      s2_upd_q    <= upd;
      s2_id_q     <= chg_id;
      s2_delta_q  <= delta;
    end
    if (s2_adv && s2_upd_q) begin
      tot_mem[s2_id_q] <= sum;
      wb_id_q          <= s2_id_q;
      wb_total_q       <= sum;
    end
    if (s2_adv) begin
      res_status_q <= s2_status_q;
      res_upd_q    <= s2_upd_q;
      res_id_q     <= s2_upd_q ? s2_id_q : '0;
      res_total_q  <= s2_upd_q ? sum : '0;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.status     = res_status_q;
  assign res_o.updated    = res_upd_q;
  assign res_o.charged_id = res_id_q;
  assign res_o.new_total  = res_total_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ETP_ASSERT_ALWAYS(a_depth_bound, depth_q <= etp_pkg::STACK_FULL,
    "stack depth beyond capacity")
  `ETP_ASSERT(a_upd_ok, res_valid_q && res_upd_q |-> res_status_q == etp_pkg::ST_OK,
    "total changed on a rejected event")
  `ETP_ASSERT(a_pop_depth, accept && do_pop |=> depth_q == $past(depth_m1),
    "accepted pop did not lower stack depth")
  `ETP_ASSERT(a_s2_hold, s2_valid_q && !s2_adv |=> s2_valid_q && $stable(s2_status_q),
    "stalled event lost from second stage")

endmodule

@@ tb/exclusive_time_profiler_test.sv @@
`timescale 1ns / 1ps

module exclusive_time_profiler_test;
  import etp_pkg::*;

  // event kinds on the trace channel
  localparam logic FN_START = 1'b0;
  localparam logic FN_END   = 1'b1;

  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  typedef struct packed {
    logic             is_end;
    logic [FID_W-1:0] func_id;
    logic [TS_W-1:0]  timestamp;
  } trace_event_t;

  typedef struct packed {
    status_e          status;
    logic             updated;
    logic [FID_W-1:0] charged_id;
    logic [TOT_W-1:0] new_total;
  } charge_t;

  logic clk;
  logic rst_n;

  etp_evt_if evt_if ();
  etp_cfg_if cfg_if ();
  etp_res_if res_if ();

  exclusive_time_profiler i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // profiler state as the checker sees it
  logic [TOT_W-1:0] fn_total [MAX_FUNCS];
  logic [FID_W-1:0] call_ids [STACK_DEPTH];
  int unsigned      nest_level;
  logic [TOT_W-1:0] slice_start;
  logic [CNT_W-1:0] func_count;

  charge_t          pending_charges [$];
  int unsigned      mismatch_count;
  logic [TS_W-1:0]  trace_clock;
  bit               gaps_on;
  bit               stalls_on;

  always #5 clk = ~clk;

  // Charge one event against the call stack; returns the result the block owes.
  function automatic charge_t charge_event(trace_event_t ev);
    charge_t          r;
    logic [TOT_W-1:0] ts;
    logic [FID_W-1:0] top;
    r  = '{status: ST_OK, updated: 1'b0, charged_id: '0, new_total: '0};
    ts = TOT_W'(ev.timestamp);
    if (ev.func_id >= func_count || ev.func_id >= MAX_FUNCS) begin
      r.status = ST_RANGE;
    end else if (ev.is_end == FN_END) begin
      if (nest_level == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // named function is charged, whatever sits on top
        nest_level--;
        fn_total[ev.func_id] = fn_total[ev.func_id] + (ts - slice_start) + 1;
        slice_start          = ts + 1;
        r.updated            = 1'b1;
        r.charged_id         = ev.func_id;
        r.new_total          = fn_total[ev.func_id];
      end
    end else if (nest_level >= STACK_DEPTH) begin
      r.status = ST_OVERFLOW;
    end else begin
      if (nest_level > 0) begin
        top           = call_ids[nest_level-1];
        fn_total[top] = fn_total[top] + (ts - slice_start);
        r.updated     = 1'b1;
        r.charged_id  = top;
        r.new_total   = fn_total[top];
      end
      slice_start          = ts;
      call_ids[nest_level] = ev.func_id;
      nest_level++;
    end
    return r;
  endfunction

  // One transfer on the trace channel; the prediction is made at the transfer.
  task automatic send_event(input logic is_end, input logic [FID_W-1:0] id,
                            input logic [TS_W-1:0] ts, output charge_t predicted);
    int unsigned  gap;
    trace_event_t ev;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    ev  = '{is_end: is_end, func_id: id, timestamp: ts};
    @(negedge clk);
    if (gap > 0) begin
      evt_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_if.is_end    = is_end;
    evt_if.func_id   = id;
    evt_if.timestamp = ts;
    evt_if.valid     = 1'b1;
    do @(posedge clk); while (!evt_if.ready);
    predicted = charge_event(ev);
    pending_charges.push_back(predicted);
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    evt_if.valid = 1'b0;
    while (pending_charges.size() != 0) @(posedge clk);
  endtask

  task automatic set_function_count(input logic [CNT_W-1:0] count);
    @(negedge clk);
    cfg_if.data  = count;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    func_count = count;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic log_mismatch(input string what, input charge_t want, input charge_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected status=%0d updated=%0b id=%0d total=%h, got status=%0d updated=%0b id=%0d total=%h",
               $realtime, what, want.status, want.updated, want.charged_id, want.new_total,
               got.status, got.updated, got.charged_id, got.new_total);
  endtask

  // Result side: random stalls on ready, each transfer checked against the oldest prediction.
  initial begin : result_monitor
    int unsigned hold;
    charge_t     got;
    charge_t     want;
    res_if.ready = 1'b0;
    forever begin
      hold = stalls_on ? $urandom_range(0, 5) : 0;
      repeat (hold) begin
        @(negedge clk);
        res_if.ready = 1'b0;
      end
      @(negedge clk);
      res_if.ready = 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
      got = '{status: res_if.status, updated: res_if.updated,
              charged_id: res_if.charged_id, new_total: res_if.new_total};
      if (pending_charges.size() == 0) begin
        log_mismatch("result with no event outstanding", '0, got);
      end else begin
        want = pending_charges.pop_front();
        if (got.status !== want.status || got.updated !== want.updated ||
            got.charged_id !== want.charged_id || got.new_total !== want.new_total)
          log_mismatch("result mismatch", want, got);
      end
    end
  end

  // Hand-picked events: empty-stack end, first start, nested charge, end naming
  // another function than the top, backwards time, total wrap, narrowing the id range.
  task automatic test_directed_cases();
    charge_t r;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_event(FN_END,   7'd0,   31'd0,  r);
    send_event(FN_START, 7'd127, 31'd0,  r);
    send_event(FN_START, 7'd0,   31'd5,  r);
    send_event(FN_END,   7'd0,   31'd9,  r);
    send_event(FN_END,   7'd3,   31'd12, r);   // pops 127, charges 3
    send_event(FN_END,   7'd1,   31'd13, r);
    send_event(FN_START, 7'd2,   TS_MAX, r);
    send_event(FN_START, 7'd4,   31'd16, r);   // time runs backwards
    send_event(FN_END,   7'd4,   TS_MAX, r);
    send_event(FN_END,   7'd2,   31'd0,  r);
    // three full-range slices push the total of 5 past 2^32
    repeat (3) begin
      send_event(FN_START, 7'd5, 31'd0,  r);
      send_event(FN_END,   7'd5, TS_MAX, r);
    end
    send_event(FN_START, 7'd100, 31'd100, r);
    drain_results();
    set_function_count(CNT_W'(10));
    send_event(FN_START, 7'd5,   31'd150, r);  // 100 still charged though out of range
    send_event(FN_END,   7'd5,   31'd160, r);
    send_event(FN_END,   7'd100, 31'd170, r);
    send_event(FN_START, 7'd10,  31'd171, r);
    send_event(FN_START, 7'd9,   31'd172, r);
    send_event(FN_END,   7'd9,   31'd180, r);
    drain_results();
    set_function_count('0);
    send_event(FN_START, 7'd0, 31'd190, r);
    send_event(FN_END,   7'd0, 31'd191, r);
    drain_results();
    set_function_count(FUNC_COUNT_RST);
  endtask

  // Fill the stack, push past it, then unwind it completely.
  task automatic test_stack_overflow();
    charge_t          r;
    logic [FID_W-1:0] id;
    drain_results();
    set_function_count(CNT_W'(64));
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (nest_level < STACK_DEPTH) begin
      trace_clock += TS_W'($urandom_range(0, 9));
      send_event(FN_START, FID_W'($urandom_range(0, 63)), trace_clock, r);
    end
    send_event(FN_START, 7'd1,   trace_clock, r);
    send_event(FN_START, 7'd63,  trace_clock, r);
    send_event(FN_START, 7'd127, trace_clock, r);   // range wins over overflow
    send_event(FN_END,   7'd100, trace_clock, r);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    while (nest_level > 0) begin
      trace_clock += TS_W'($urandom_range(0, 9));
      id = call_ids[nest_level-1];
      if (id >= func_count) id = FID_W'($urandom_range(0, 63));
      send_event(FN_END, id, trace_clock, r);
    end
    send_event(FN_END, 7'd100, trace_clock, r);     // range wins over empty
    send_event(FN_END, 7'd0,   trace_clock, r);
  endtask

  // Mostly well-formed nesting with random ids and times, plus some noise.
  function automatic trace_event_t next_trace_event(int unsigned max_nest);
    trace_event_t     ev;
    logic [FID_W-1:0] hi;
    hi = (func_count == 0 || func_count > MAX_FUNCS) ? FID_W'(MAX_FUNCS - 1)
                                                     : FID_W'(func_count - 1);
    if ($urandom_range(0, 99) < 85) begin
      trace_clock += ($urandom_range(0, 3) == 0) ? TS_W'($urandom_range(0, 1 << 20))
                                                 : TS_W'($urandom_range(0, 12));
      ev.timestamp = trace_clock;
      if (nest_level == 0 || (nest_level < max_nest && $urandom_range(0, 1) == 1)) begin
        ev.is_end  = FN_START;
        ev.func_id = FID_W'($urandom_range(0, hi));
      end else begin
        ev.is_end  = FN_END;
        ev.func_id = call_ids[nest_level-1];
        if (ev.func_id > hi) ev.func_id = FID_W'($urandom_range(0, hi));
      end
    end else begin
      ev.is_end  = $urandom_range(0, 1) ? FN_END : FN_START;
      ev.func_id = FID_W'($urandom_range(0, MAX_FUNCS - 1));
      if ($urandom_range(0, 3) == 0) trace_clock = TS_W'($urandom_range(0, 32'h7FFF_FFFF));
      ev.timestamp = trace_clock;
    end
    return ev;
  endfunction

  task automatic run_trace_segment(input logic [CNT_W-1:0] count, input int unsigned target,
                                   input int unsigned max_nest, input int unsigned mode);
    int unsigned  charged;
    trace_event_t ev;
    charge_t      r;
    drain_results();
    set_function_count(count);
    gaps_on   = mode[0];
    stalls_on = mode[1];
    charged   = 0;
    while (charged < target) begin
      ev = next_trace_event(max_nest);
      send_event(ev.is_end, ev.func_id, ev.timestamp, r);
      // with no ids in range nothing is ever charged, so count every event
      if (r.status == ST_OK || func_count == 0) charged++;
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  task automatic test_random_traces();
    run_trace_segment(CNT_W'(128), 80, 6, 3);
    run_trace_segment(CNT_W'(1),   40, 4, 0);
    run_trace_segment(CNT_W'(2),   40, 8, 1);
    run_trace_segment('0,          20, 4, 2);
    run_trace_segment(CNT_W'(255), 80, 70, 3);
    run_trace_segment(CNT_W'($urandom_range(3, 127)), 80, 12, 2);
    run_trace_segment(CNT_W'(64),  60, 3, 1);
    run_trace_segment(FUNC_COUNT_RST, 80, 10, 3);
  endtask

  initial begin : sequencer
    clk              = 1'b0;
    rst_n            = 1'b0;
    evt_if.valid     = 1'b0;
    evt_if.is_end    = FN_START;
    evt_if.func_id   = '0;
    evt_if.timestamp = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    foreach (fn_total[i]) fn_total[i] = '0;
    foreach (call_ids[i]) call_ids[i] = '0;
    nest_level     = 0;
    slice_start    = '0;
    func_count     = FUNC_COUNT_RST;
    mismatch_count = 0;
    trace_clock    = '0;
    gaps_on        = 1'b0;
    stalls_on      = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_stack_overflow();
    test_random_traces();

    drain_results();
    // results pass through two registers after a transfer; leave room for strays
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_charges.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
